@@ sv/tdl_pkg.sv @@
package tdl_pkg;

    // input item kinds (tuser of the slave side)
    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_TEXT     = 2'd1;
    localparam logic [1:0] OP_NEW_TEXT = 2'd2;

    // result record kinds (tuser of the master side)
    localparam logic [1:0] REC_CHAR  = 2'd0;
    localparam logic [1:0] REC_TOKEN = 2'd1;
    localparam logic [1:0] REC_ERROR = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 80;
    localparam int POS_FIELD_W = 16;
    localparam int TOK_FIELD_W = 4;

    typedef struct packed {
        logic [3:0] next;
        logic       valid;
        logic [3:0] token;
        logic       skip;
        logic       keep;
        logic       reproc;
    } t_entry;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_val;
        logic [3:0] load_state;
        logic       char_oor;   // text byte beyond the character range
        t_entry     entry;
    } t_cmd;

    typedef struct packed {
        logic [1:0]             rtype;
        logic [7:0]             char_out;
        logic [TOK_FIELD_W-1:0] token_code;
        logic [POS_FIELD_W-1:0] start_line;
        logic [POS_FIELD_W-1:0] start_column;
        logic [POS_FIELD_W-1:0] end_line;
        logic [POS_FIELD_W-1:0] end_column;
        logic                   last;
    } t_rec;

endpackage

@@ sv/tdl_front.sv @@
module tdl_front #(
    parameter int NUM_STATES = 16,
    parameter int NUM_CHARS  = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [tdl_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  logic [1:0]                        i_s_tuser,
    input  logic                              i_clearing,
    output logic                              o_cmd_valid,
    output tdl_pkg::t_cmd                     o_cmd,
    input  logic                              i_cmd_pop
);
    import tdl_pkg::*;

    t_cmd       r_q [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    t_cmd c_cmd;
    logic c_keep;
    logic c_load_ok;
    logic c_push;

    always_comb begin
        c_cmd.kind         = i_s_tuser;
        c_cmd.char_val     = i_s_tdata[7:0];
        c_cmd.load_state   = i_s_tdata[11:8];
        c_cmd.entry.next   = i_s_tdata[15:12];
        c_cmd.entry.valid  = i_s_tdata[16];
        c_cmd.entry.token  = i_s_tdata[20:17];
        c_cmd.entry.skip   = i_s_tdata[21];
        c_cmd.entry.keep   = i_s_tdata[22];
        c_cmd.entry.reproc = i_s_tdata[23];
        c_cmd.char_oor     = ({24'd0, i_s_tdata[7:0]} >= NUM_CHARS);
        c_load_ok          = ({28'd0, i_s_tdata[11:8]} < NUM_STATES) && !c_cmd.char_oor;
        // out-of-range loads and unused opcodes are dropped here
        c_keep = ((i_s_tuser == OP_LOAD) && c_load_ok) ||
                 (i_s_tuser == OP_TEXT) || (i_s_tuser == OP_NEW_TEXT);
    end

    assign o_s_tready  = (r_cnt != 2'd2) && !i_clearing;
    assign c_push      = i_s_tvalid && o_s_tready && c_keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt + {1'b0, c_push} - {1'b0, i_cmd_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (c_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_q[r_wp] <= c_cmd;
        end
    end

endmodule

@@ sv/tdl_out_fifo.sv @@
module tdl_out_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_push_n,
    input  tdl_pkg::t_rec [2:0]   i_push_rec,
    output logic                  o_room,
    output logic                  o_valid,
    output tdl_pkg::t_rec         o_rec,
    input  logic                  i_pop
);
    import tdl_pkg::*;

    t_rec       r_buf [0:3];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       c_pop;

    // room for a full burst of three records
    assign o_room  = (r_cnt < 3'd2);
    assign o_valid = (r_cnt != 3'd0);
    assign o_rec   = r_buf[r_rp];
    assign c_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= r_wp + i_push_n;
            r_cnt <= r_cnt + {1'b0, i_push_n} - {2'd0, c_pop};
            if (c_pop) begin
                r_rp <= r_rp + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < i_push_n) begin
                r_buf[r_wp + 2'(k)] <= i_push_rec[k];
            end
        end
    end

endmodule

@@ sv/tdl_engine.sv @@
module tdl_engine #(
    parameter int NUM_STATES = 16,
    parameter int NUM_CHARS  = 256,
    parameter int POS_BITS   = 16,
    parameter int TOKEN_BITS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  tdl_pkg::t_cmd        i_cmd,
    output logic                 o_cmd_pop,
    output logic                 o_clearing,
    input  logic                 i_out_room,
    output logic [1:0]           o_push_n,
    output tdl_pkg::t_rec [2:0]  o_push_rec
);
    import tdl_pkg::*;

    localparam int SB    = $clog2(NUM_STATES);
    localparam int CB    = $clog2(NUM_CHARS);
    localparam int AW    = SB + CB;
    localparam int DEPTH = 1 << AW;
    localparam int ENT_W = 4 + 1 + TOKEN_BITS + 3;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;

    logic [ENT_W-1:0] r_mem [0:DEPTH-1];
    logic [ENT_W-1:0] r_rd;
    logic             r_rd_inv;

    logic [1:0]          r_fsm, n_fsm;
    logic [AW-1:0]       r_clr, n_clr;
    logic [3:0]          r_cur, n_cur;
    logic [POS_BITS-1:0] r_line, n_line, r_col, n_col;
    logic [POS_BITS-1:0] r_tsl, n_tsl, r_tsc, n_tsc;
    logic                r_err, n_err;
    logic [7:0]          r_char, n_char;
    logic                r_oor, n_oor;
    logic                r_pass, n_pass;
    logic                r_pend_v, n_pend_v;
    t_rec                r_pend, n_pend;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             rd_inv;

    logic [3:0]            e_next;
    logic                  e_valid;
    logic [TOKEN_BITS-1:0] e_tok;
    logic                  e_skip, e_keep, e_reproc;

    function automatic logic [AW-1:0] tbl_addr(logic [3:0] st, logic [7:0] ch);
        logic [7:0] se;
        se = {4'd0, st};
        return {se[SB-1:0], ch[CB-1:0]};
    endfunction

    function automatic logic state_ok(logic [3:0] st);
        return ({28'd0, st} < NUM_STATES);
    endfunction

    function automatic logic [POS_FIELD_W-1:0] pos_field(logic [POS_BITS-1:0] v);
        logic [POS_BITS+POS_FIELD_W-1:0] w;
        w = {{POS_FIELD_W{1'b0}}, v};
        return w[POS_FIELD_W-1:0];
    endfunction

    function automatic logic [TOK_FIELD_W-1:0] tok_field(logic [TOKEN_BITS-1:0] v);
        logic [TOKEN_BITS+TOK_FIELD_W-1:0] w;
        w = {{TOK_FIELD_W{1'b0}}, v};
        return w[TOK_FIELD_W-1:0];
    endfunction

    function automatic logic [ENT_W-1:0] pack_entry(t_entry e);
        logic [TOKEN_BITS+3:0] tw;
        tw = {{TOKEN_BITS{1'b0}}, e.token};
        return {e.next, e.valid, tw[TOKEN_BITS-1:0], e.skip, e.keep, e.reproc};
    endfunction

    assign e_next   = r_rd[ENT_W-1 -: 4];
    assign e_valid  = r_rd[ENT_W-5] && !r_rd_inv;
    assign e_tok    = r_rd[3 +: TOKEN_BITS];
    assign e_skip   = r_rd[2];
    assign e_keep   = r_rd[1];
    assign e_reproc = r_rd[0];

    assign o_clearing = (r_fsm == ST_CLEAR);

    always_comb begin
        t_rec       rec_mid, rec_tok;
        logic       v_pend, v_mid, v_tok;
        logic [1:0] k;

        n_fsm    = r_fsm;
        n_clr    = r_clr;
        n_cur    = r_cur;
        n_line   = r_line;
        n_col    = r_col;
        n_tsl    = r_tsl;
        n_tsc    = r_tsc;
        n_err    = r_err;
        n_char   = r_char;
        n_oor    = r_oor;
        n_pass   = r_pass;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;

        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        rd_inv     = 1'b0;
        o_cmd_pop  = 1'b0;
        o_push_n   = 2'd0;
        o_push_rec = '0;

        rec_mid = '0;
        rec_tok = '0;
        v_pend  = 1'b0;
        v_mid   = 1'b0;
        v_tok   = 1'b0;
        k       = 2'd0;

        unique case (r_fsm)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_fsm = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        OP_LOAD: begin
                            mem_we    = 1'b1;
                            mem_waddr = tbl_addr(i_cmd.load_state, i_cmd.char_val);
                            mem_wdata = pack_entry(i_cmd.entry);
                        end
                        OP_NEW_TEXT: begin
                            n_cur  = 4'd0;
                            n_line = POS_BITS'(1);
                            n_col  = '0;
                            n_tsl  = POS_BITS'(1);
                            n_tsc  = '0;
                            n_err  = 1'b0;
                        end
                        OP_TEXT: begin
                            if (!r_err) begin
                                if (i_cmd.char_val == CHAR_NEWLINE) begin
                                    if (r_line != '1) begin
                                        n_line = r_line + 1'b1;
                                    end
                                    n_col = '0;
                                end else if (r_col != '1) begin
                                    n_col = r_col + 1'b1;
                                end
                                n_char   = i_cmd.char_val;
                                n_oor    = i_cmd.char_oor;
                                rd_en    = 1'b1;
                                rd_addr  = tbl_addr(r_cur, i_cmd.char_val);
                                rd_inv   = i_cmd.char_oor || !state_ok(r_cur);
                                n_pass   = 1'b0;
                                n_pend_v = 1'b0;
                                n_fsm    = ST_EVAL;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_EVAL: begin
                if (i_out_room) begin
                    v_pend = r_pend_v;
                    if (!e_valid) begin
                        v_mid            = 1'b1;
                        rec_mid.rtype    = REC_ERROR;
                        rec_mid.char_out = r_char;
                        rec_mid.end_line   = pos_field(r_line);
                        rec_mid.end_column = pos_field(r_col);
                        n_err = 1'b1;
                        n_fsm = ST_IDLE;
                    end else begin
                        // reprocess entries never keep the character
                        v_mid            = e_keep && !e_reproc;
                        rec_mid.rtype    = REC_CHAR;
                        rec_mid.char_out = r_char;
                        if (e_next == 4'd0) begin
                            v_tok = !e_skip;
                            n_tsl = r_line;
                            n_tsc = r_col;
                        end
                        rec_tok.rtype        = REC_TOKEN;
                        rec_tok.token_code   = tok_field(e_tok);
                        rec_tok.start_line   = pos_field(r_tsl);
                        rec_tok.start_column = pos_field(r_tsc);
                        rec_tok.end_line     = pos_field(r_line);
                        rec_tok.end_column   = pos_field(r_col);
                        n_cur = e_next;
                        if (e_reproc && !r_pass) begin
                            // hold the first-pass token until the run's end is known
                            v_mid    = 1'b0;
                            v_tok    = 1'b0;
                            n_pend_v = !e_skip && (e_next == 4'd0);
                            n_pend   = rec_tok;
                            n_pass   = 1'b1;
                            rd_en    = 1'b1;
                            rd_addr  = tbl_addr(e_next, r_char);
                            rd_inv   = r_oor || !state_ok(e_next);
                        end else begin
                            n_fsm = ST_IDLE;
                        end
                    end
                    if (n_fsm == ST_IDLE) begin
                        if (v_pend) begin
                            o_push_rec[k] = r_pend;
                            k = k + 2'd1;
                        end
                        if (v_mid) begin
                            o_push_rec[k] = rec_mid;
                            k = k + 2'd1;
                        end
                        if (v_tok) begin
                            o_push_rec[k] = rec_tok;
                            k = k + 2'd1;
                        end
                        if (k != 2'd0) begin
                            o_push_rec[k - 2'd1].last = 1'b1;
                        end
                        o_push_n = k;
                        n_pend_v = 1'b0;
                    end
                end
            end
            default: begin
                n_fsm = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= ST_CLEAR;
            r_clr    <= '0;
            r_cur    <= 4'd0;
            r_line   <= POS_BITS'(1);
            r_col    <= '0;
            r_tsl    <= POS_BITS'(1);
            r_tsc    <= '0;
            r_err    <= 1'b0;
            r_pass   <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_fsm    <= n_fsm;
            r_clr    <= n_clr;
            r_cur    <= n_cur;
            r_line   <= n_line;
            r_col    <= n_col;
            r_tsl    <= n_tsl;
            r_tsc    <= n_tsc;
            r_err    <= n_err;
            r_pass   <= n_pass;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_oor  <= n_oor;
        r_pend <= n_pend;
    end

    // transition table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd     <= r_mem[rd_addr];
            r_rd_inv <= rd_inv;
        end
    end

endmodule

@@ sv/table_driven_lexer_top.sv @@
// Programmable DFA tokenizer. Requests on the slave side either load one
// transition-table entry (state x character), feed one text byte, or start a
// new text; the master side streams records: kept token characters, completed
// tokens with start and end line/column, and an invalid-character error that
// stays sticky until the next new-text request. After reset the table is swept
// to invalid, one entry per cycle, all 2^(clog2(NUM_STATES)+clog2(NUM_CHARS))
// entries (4096 by default); tready stays low during the sweep. Afterwards a
// text byte passes through a synchronous table read and then an evaluate step,
// with a second read and evaluate when its entry asks for the byte to be
// reprocessed; load and new-text requests complete in idle. A command queue
// parts the input from the engine and a result queue parts the engine from
// the output, so input keeps flowing while records wait, until the two-entry
// command queue fills; the engine evaluates only with three free result slots.
module table_driven_lexer_top #(
    parameter int NUM_STATES = 16,
    parameter int NUM_CHARS  = 256,
    parameter int POS_BITS   = 16,
    parameter int TOKEN_BITS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request side
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // byte_value, load_state, entry_next_state, entry_valid, entry_token,
    // entry_skip, entry_keep_char, entry_reprocess
    input  logic [tdl_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // opcode
    input  logic [1:0]                          i_s_axis_tuser,
    // record side
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // char_out, token_code, start_line, start_column, end_line, end_column,
    // zero pad
    output logic [tdl_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // record_type
    output logic [1:0]                          o_m_axis_tuser,
    // last_in_run
    output logic                                o_m_axis_tlast
);
    import tdl_pkg::*;

    logic       cmd_valid;
    t_cmd       cmd;
    logic       cmd_pop;
    logic       clearing;
    logic       out_room;
    logic [1:0] push_n;
    t_rec [2:0] push_rec;
    t_rec       out_rec;

    // front: accept, classify, queue commands
    tdl_front #(
        .NUM_STATES (NUM_STATES),
        .NUM_CHARS  (NUM_CHARS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_axis_tvalid),
        .o_s_tready  (o_s_axis_tready),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .i_clearing  (clearing),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // back: table, state, positions
    tdl_engine #(
        .NUM_STATES (NUM_STATES),
        .NUM_CHARS  (NUM_CHARS),
        .POS_BITS   (POS_BITS),
        .TOKEN_BITS (TOKEN_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_clearing  (clearing),
        .i_out_room  (out_room),
        .o_push_n    (push_n),
        .o_push_rec  (push_rec)
    );

    // result queue, up to three records pushed per cycle
    tdl_out_fifo u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_n   (push_n),
        .i_push_rec (push_rec),
        .o_room     (out_room),
        .o_valid    (o_m_axis_tvalid),
        .o_rec      (out_rec),
        .i_pop      (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {4'd0, out_rec.end_column, out_rec.end_line,
                             out_rec.start_column, out_rec.start_line,
                             out_rec.token_code, out_rec.char_out};
    assign o_m_axis_tuser = out_rec.rtype;
    assign o_m_axis_tlast = out_rec.last;

endmodule

@@ sv/tdl_checker.sv @@
module tdl_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [tdl_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input logic [1:0]                       o_m_axis_tuser,
    input logic                             o_m_axis_tlast
);
    import tdl_pkg::*;

    // reset empties the record queue
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("record valid right after reset");

    // reset starts the table sweep, no requests taken
    a_rst_sweep: assert property (@(posedge i_clk) !i_rst_n |=> !o_s_axis_tready)
        else $error("request taken during table sweep");

    // stalled record holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) &&
        $stable(o_m_axis_tlast))
        else $error("stalled record changed");

    // an error always closes the run of its byte
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == REC_ERROR) |-> o_m_axis_tlast)
        else $error("error record not last in run");

    // kept characters carry no positions
    a_char_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == REC_CHAR) |-> (o_m_axis_tdata[79:8] == '0))
        else $error("character record carries position data");

endmodule

bind table_driven_lexer_top tdl_checker u_tdl_checker (.*);
